// File: rtl/sgt_pkg.sv
// ----------------------------------------------------------------------------
// sgt_pkg: shared types and constants of the segment translator
// Table geometry, field widths, codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package sgt_pkg;

   localparam int TABLE_DEPTH     = 1024;
   localparam int PAGE_BYTES      = 4096;   // a power of two
   localparam int MAX_DESCRIPTORS = 64;

   localparam int TAW        = $clog2(TABLE_DEPTH);   // table address bits
   localparam int CNTW       = TAW + 1;               // entry count bits
   localparam int PAGE_BITS  = $clog2(PAGE_BYTES);
   localparam int NDW        = $clog2(MAX_DESCRIPTORS + 1);
   localparam int ADDRW      = 64;
   localparam int LENW       = 32;
   localparam int OFFW       = 48;
   localparam int CURW       = OFFW + 2;              // offset walk may pass 2^48
   localparam int ENTRYW     = ADDRW + LENW;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_SEG   = 2'd1;
   localparam logic [1:0] MODE_REV   = 2'd2;
   localparam logic [1:0] MODE_CLEAR = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_TRUNC     = 2'd3;

   typedef struct packed {
      logic       capture;     // latch the request fields
      logic       scan_init;   // restart the table walk at entry zero
      logic       rd;          // read the entry at the walk index
      logic       step;        // move past the entry just checked
      logic       take;        // keep the matching entry
      logic       calc;        // form address and bytes left in the entry
      logic       load;        // append an entry
      logic       clear;       // empty the table
      logic       rsp_plain;   // one result word with status only
      logic [1:0] rsp_status;
      logic       rsp_desc;    // one descriptor word
      logic       rsp_rev;     // one reverse lookup word
   } cmd_type;

   typedef struct packed {
      logic full;
      logic size_zero;
      logic at_end;
      logic hit;
      logic desc_final;
   } stat_type;

endpackage

// File: rtl/sg_dma_segment_translator.sv
// ----------------------------------------------------------------------------
// sg_dma_segment_translator: scatter-gather table and descriptor generator
// Loads and clears a table of entries, splits buffer segments into descriptors
// cut at a page end if begun mid-page; maps physical addresses back to offsets.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake           Payload
//   --------  ------------------  ---------------------------------------------
//   request   start / busy        req_mode, req_address, req_entry_length,
//                                 req_offset, req_size
//   result    rsp_valid (strobe)  rsp_status, rsp_desc_address, rsp_desc_length,
//                                 rsp_offset_out, rsp_last
//
// A load or clear word keeps the block idle, ready for the next word at once.
// A lookup walks the table from entry zero, reading an entry (S_RD) and then
// comparing it (S_CHK). A segment request repeats that walk for every
// descriptor and then forms it (S_CALC, S_EMIT), for up to 64 descriptors.
// Reset is synchronous and empties the table; stored entries are not cleared.
// Each result word is shown for exactly one cycle; the receiver cannot stall.
module sg_dma_segment_translator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_mode,
   input  logic [sgt_pkg::ADDRW-1:0] req_address,
   input  logic [sgt_pkg::LENW-1:0]  req_entry_length,
   input  logic [sgt_pkg::OFFW-1:0]  req_offset,
   input  logic [sgt_pkg::OFFW-1:0]  req_size,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_status,
   output logic [sgt_pkg::ADDRW-1:0] rsp_desc_address,
   output logic [sgt_pkg::LENW-1:0]  rsp_desc_length,
   output logic [sgt_pkg::OFFW-1:0]  rsp_offset_out,
   output logic                      rsp_last
);

   sgt_pkg::cmd_type  cmd;
   sgt_pkg::stat_type stat;
   logic [1:0]        mode;

   // The controller owns sequencing and the request mode of the current word.
   sgt_control u_control (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .busy     (busy),
      .mode     (mode),
      .cmd      (cmd),
      .stat     (stat)
   );

   // The datapath holds the table, the walk registers and the result word.
   sgt_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .mode             (mode),
      .req_address      (req_address),
      .req_entry_length (req_entry_length),
      .req_offset       (req_offset),
      .req_size         (req_size),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_desc_address (rsp_desc_address),
      .rsp_desc_length  (rsp_desc_length),
      .rsp_offset_out   (rsp_offset_out),
      .rsp_last         (rsp_last)
   );

endmodule

// File: rtl/sgt_ram.sv
// ----------------------------------------------------------------------------
// sgt_ram: generic single-port-write, registered-read memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module sgt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/sgt_datapath.sv
// ----------------------------------------------------------------------------
// sgt_datapath: table storage, walk arithmetic and result registers
// Executes the controller's commands and reports match and end conditions.
// ----------------------------------------------------------------------------
module sgt_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  sgt_pkg::cmd_type         cmd,
   output sgt_pkg::stat_type        stat,
   input  logic [1:0]               mode,
   input  logic [sgt_pkg::ADDRW-1:0] req_address,
   input  logic [sgt_pkg::LENW-1:0]  req_entry_length,
   input  logic [sgt_pkg::OFFW-1:0]  req_offset,
   input  logic [sgt_pkg::OFFW-1:0]  req_size,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic [sgt_pkg::ADDRW-1:0] rsp_desc_address,
   output logic [sgt_pkg::LENW-1:0]  rsp_desc_length,
   output logic [sgt_pkg::OFFW-1:0]  rsp_offset_out,
   output logic                     rsp_last
);

   localparam int AW = sgt_pkg::ADDRW;
   localparam int LW = sgt_pkg::LENW;
   localparam int OW = sgt_pkg::OFFW;
   localparam int CW = sgt_pkg::CURW;
   localparam int PB = sgt_pkg::PAGE_BITS;

   // Control state.
   logic [sgt_pkg::CNTW-1:0] count_ff, count_in;
   logic [OW-1:0]            total_ff, total_in;
   logic                     valid_ff, valid_in;

   // Payload state.
   logic [sgt_pkg::CNTW-1:0] idx_ff, idx_in;
   logic [OW-1:0]            base_ff, base_in;
   logic [CW-1:0]            cur_ff, cur_in;
   logic [OW-1:0]            rem_ff, rem_in;
   logic [sgt_pkg::NDW-1:0]  nd_ff, nd_in;
   logic [AW-1:0]            addr_ff, addr_in;
   logic [AW-1:0]            ent_ff, ent_in;
   logic [LW-1:0]            len_ff, len_in;
   logic [AW-1:0]            diff_ff, diff_in;
   logic [AW-1:0]            phys_ff, phys_in;
   logic [LW-1:0]            left_ff, left_in;
   logic [1:0]               st_ff, st_in;
   logic [AW-1:0]            da_ff, da_in;
   logic [LW-1:0]            dl_ff, dl_in;
   logic [OW-1:0]            oo_ff, oo_in;
   logic                     last_ff, last_in;

   logic [sgt_pkg::ENTRYW-1:0] rdata;
   logic [AW-1:0]              r_addr;
   logic [LW-1:0]              r_len;

   sgt_ram #(
      .WIDTH(sgt_pkg::ENTRYW),
      .DEPTH(sgt_pkg::TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (cmd.load),
      .waddr (count_ff[sgt_pkg::TAW-1:0]),
      .wdata ({req_address, req_entry_length}),
      .re    (cmd.rd),
      .raddr (idx_ff[sgt_pkg::TAW-1:0]),
      .rdata (rdata)
   );

   assign r_addr = rdata[sgt_pkg::ENTRYW-1:LW];
   assign r_len  = rdata[LW-1:0];

   // Match tests against the entry just read.
   logic [CW-1:0] off_d;
   logic [AW-1:0] addr_d;
   logic          seg_hit, rev_hit;

   assign off_d   = cur_ff - {{(CW-OW){1'b0}}, base_ff};
   assign seg_hit = (cur_ff >= {{(CW-OW){1'b0}}, base_ff})
                    && (off_d < {{(CW-LW){1'b0}}, r_len});
   assign addr_d  = addr_ff - r_addr;
   assign rev_hit = addr_d < {{(AW-LW){1'b0}}, r_len};

   // Descriptor arithmetic on the located piece.
   logic [PB-1:0] in_page;
   logic [PB:0]   to_bound;
   logic [LW-1:0] seg_pg;
   logic [OW-1:0] seg;
   logic [OW-1:0] rem_n;
   logic [CW-1:0] cur_n;
   logic          fin_nd;

   always_comb begin
      in_page  = phys_ff[PB-1:0];
      to_bound = (PB+1)'(sgt_pkg::PAGE_BYTES) - {1'b0, in_page};
      seg_pg   = left_ff;
      if ((in_page != '0) && ({{(LW-PB-1){1'b0}}, to_bound} < left_ff)) begin
         seg_pg = {{(LW-PB-1){1'b0}}, to_bound};
      end
      seg = {{(OW-LW){1'b0}}, seg_pg};
      if (seg >= rem_ff) begin
         seg = rem_ff;
      end
      rem_n  = rem_ff - seg;
      cur_n  = cur_ff + {{(CW-OW){1'b0}}, seg};
      fin_nd = (nd_ff == sgt_pkg::NDW'(sgt_pkg::MAX_DESCRIPTORS - 1));
   end

   always_comb begin
      stat.full       = (count_ff == sgt_pkg::CNTW'(sgt_pkg::TABLE_DEPTH));
      stat.size_zero  = (req_size == '0);
      stat.at_end     = (idx_ff == count_ff);
      stat.hit        = (mode == sgt_pkg::MODE_REV) ? rev_hit : seg_hit;
      stat.desc_final = (rem_n == '0) || fin_nd;
   end

   always_comb begin
      count_in = count_ff;
      total_in = total_ff;
      idx_in   = idx_ff;
      base_in  = base_ff;
      cur_in   = cur_ff;
      rem_in   = rem_ff;
      nd_in    = nd_ff;
      addr_in  = addr_ff;
      ent_in   = ent_ff;
      len_in   = len_ff;
      diff_in  = diff_ff;
      phys_in  = phys_ff;
      left_in  = left_ff;
      st_in    = st_ff;
      da_in    = da_ff;
      dl_in    = dl_ff;
      oo_in    = oo_ff;
      last_in  = last_ff;
      valid_in = 1'b0;

      if (cmd.capture) begin
         addr_in = req_address;
         cur_in  = {{(CW-OW){1'b0}}, req_offset};
         rem_in  = req_size;
         nd_in   = '0;
      end
      if (cmd.scan_init) begin
         idx_in  = '0;
         base_in = '0;
      end
      if (cmd.step) begin
         idx_in  = idx_ff + 1'b1;
         base_in = base_ff + {{(OW-LW){1'b0}}, r_len};
      end
      if (cmd.take) begin
         ent_in  = r_addr;
         len_in  = r_len;
         diff_in = (mode == sgt_pkg::MODE_REV) ? addr_d : {{(AW-CW){1'b0}}, off_d};
      end
      if (cmd.calc) begin
         phys_in = ent_ff + diff_ff;
         left_in = len_ff - diff_ff[LW-1:0];
      end
      if (cmd.load) begin
         count_in = count_ff + 1'b1;
         total_in = total_ff + {{(OW-LW){1'b0}}, req_entry_length};
      end
      if (cmd.clear) begin
         count_in = '0;
         total_in = '0;
      end
      if (cmd.rsp_plain) begin
         valid_in = 1'b1;
         st_in    = cmd.rsp_status;
         da_in    = '0;
         dl_in    = '0;
         oo_in    = '0;
         last_in  = 1'b1;
      end
      if (cmd.rsp_rev) begin
         valid_in = 1'b1;
         st_in    = sgt_pkg::ST_OK;
         da_in    = '0;
         dl_in    = '0;
         oo_in    = base_ff + diff_ff[OW-1:0];
         last_in  = 1'b1;
      end
      if (cmd.rsp_desc) begin
         valid_in = 1'b1;
         st_in    = ((rem_n != '0) && fin_nd) ? sgt_pkg::ST_TRUNC : sgt_pkg::ST_OK;
         da_in    = phys_ff;
         dl_in    = seg[LW-1:0];
         oo_in    = '0;
         last_in  = (rem_n == '0) || fin_nd;
         rem_in   = rem_n;
         nd_in    = nd_ff + 1'b1;
         cur_in   = (cur_n == {{(CW-OW){1'b0}}, total_ff}) ? '0 : cur_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         total_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         total_ff <= total_in;
         valid_ff <= valid_in;
      end
      idx_ff  <= idx_in;
      base_ff <= base_in;
      cur_ff  <= cur_in;
      rem_ff  <= rem_in;
      nd_ff   <= nd_in;
      addr_ff <= addr_in;
      ent_ff  <= ent_in;
      len_ff  <= len_in;
      diff_ff <= diff_in;
      phys_ff <= phys_in;
      left_ff <= left_in;
      st_ff   <= st_in;
      da_ff   <= da_in;
      dl_ff   <= dl_in;
      oo_ff   <= oo_in;
      last_ff <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = st_ff;
   assign rsp_desc_address = da_ff;
   assign rsp_desc_length  = dl_ff;
   assign rsp_offset_out   = oo_ff;
   assign rsp_last         = last_ff;

endmodule

// File: rtl/sgt_control.sv
// ----------------------------------------------------------------------------
// sgt_control: sequencing state machine of the segment translator
// Decodes each request word and steps the datapath through table walks.
// ----------------------------------------------------------------------------
module sgt_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_mode,
   output logic              busy,
   output logic [1:0]        mode,
   output sgt_pkg::cmd_type  cmd,
   input  sgt_pkg::stat_type stat
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_CHK  = 3'd2;
   localparam logic [2:0] S_CALC = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;
   localparam logic [2:0] S_REV  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] mode_ff, mode_in;

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in = req_mode;
               unique case (req_mode)
                  sgt_pkg::MODE_LOAD: begin
                     cmd.rsp_plain = 1'b1;
                     if (stat.full) begin
                        cmd.rsp_status = sgt_pkg::ST_FULL;
                     end else begin
                        cmd.load       = 1'b1;
                        cmd.rsp_status = sgt_pkg::ST_OK;
                     end
                  end
                  sgt_pkg::MODE_CLEAR: begin
                     cmd.clear      = 1'b1;
                     cmd.rsp_plain  = 1'b1;
                     cmd.rsp_status = sgt_pkg::ST_OK;
                  end
                  sgt_pkg::MODE_REV: begin
                     cmd.capture   = 1'b1;
                     cmd.scan_init = 1'b1;
                     state_in      = S_RD;
                  end
                  default: begin
                     cmd.capture = 1'b1;
                     if (stat.size_zero) begin
                        cmd.rsp_plain  = 1'b1;
                        cmd.rsp_status = sgt_pkg::ST_OK;
                     end else begin
                        cmd.scan_init = 1'b1;
                        state_in      = S_RD;
                     end
                  end
               endcase
            end
         end
         S_RD: begin
            if (stat.at_end) begin
               cmd.rsp_plain  = 1'b1;
               cmd.rsp_status = sgt_pkg::ST_NOT_FOUND;
               state_in       = S_IDLE;
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (stat.hit) begin
               cmd.take = 1'b1;
               state_in = (mode_ff == sgt_pkg::MODE_REV) ? S_REV : S_CALC;
            end else begin
               cmd.step = 1'b1;
               state_in = S_RD;
            end
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            cmd.rsp_desc = 1'b1;
            if (stat.desc_final) begin
               state_in = S_IDLE;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = S_RD;
            end
         end
         S_REV: begin
            cmd.rsp_rev = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mode_ff <= mode_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign mode = mode_ff;

endmodule
